/* sv/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam logic [15:0] HUE_FULL_TURN = 16'd46080;
  localparam logic [12:0] HUE_SECTOR    = 13'd7680;
  localparam logic [12:0] FRAC_ONE      = 13'd4096;

  // sector start angles in 1/128 degree
  localparam logic [15:0] SEC1_BASE = 16'd7680;
  localparam logic [15:0] SEC2_BASE = 16'd15360;
  localparam logic [15:0] SEC3_BASE = 16'd23040;
  localparam logic [15:0] SEC4_BASE = 16'd30720;
  localparam logic [15:0] SEC5_BASE = 16'd38400;

  // 1.0 as a weight numerator: FRAC_ONE * HUE_SECTOR
  localparam logic [24:0] WEIGHT_ONE = 25'd31457280;

  // 255 / (4096 * 4096 * 7680) = 17 / 2^33
  localparam int unsigned SCALE_SHIFT = 33;

  // cycles through one channel datapath
  localparam int unsigned CHAN_LATENCY = 4;
  // cycles from an accepted start to done
  localparam int unsigned LATENCY      = 3 + CHAN_LATENCY;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [12:0] saturation;
    logic [12:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } rgb_t;

endpackage

/* sv/hsv2rgb_chan.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// One color channel: level = floor(17 * v * (WEIGHT_ONE - s * x) / 2^33), four stages.
// ----------------------------------------------------------------------------
module hsv2rgb_chan
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic [12:0] sat,
  input  logic [12:0] val,
  input  logic [12:0] wsel,
  output logic [7:0]  level
);

  logic [25:0] sx_full;
  logic [24:0] sx;
  logic [12:0] val1;
  logic [24:0] weight;
  logic [12:0] val2;
  logic [37:0] prod;
  logic [42:0] scaled;

  assign sx_full = 26'(sat) * 26'(wsel);

  always_ff @(posedge clk) begin
    sx   <= sx_full[24:0];
    val1 <= val;
  end

  always_ff @(posedge clk) begin
    weight <= WEIGHT_ONE - sx;
    val2   <= val1;
  end

  always_ff @(posedge clk) begin
    prod <= 38'(val2) * 38'(weight);
  end

  // times 17 as shift and add
  assign scaled = (43'(prod) << 4) + 43'(prod);

  always_ff @(posedge clk) begin
    level <= scaled[SCALE_SHIFT +: 8];
  end

endmodule

/* sv/hsv_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to 8-bit RGB color conversion, fully pipelined.
// A taken start beat passes stages 1 to 3 and then the channel pipeline; done rises with rgb.
// Throughput: one beat per cycle outside reset; every stage takes a new beat each cycle.
// busy is high only while rst is high; results cannot be held off.
// Reset clears the valid pipeline only; in-flight beats are dropped.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsv_t hsv,
  output logic done,
  output rgb_t rgb
);

  logic [LATENCY-1:0] valid;
  logic               take;

  logic [15:0] h1;
  logic [12:0] s1;
  logic [12:0] v1;

  sector_t     sec_next;
  logic [15:0] base_next;
  sector_t     sec2;
  logic [12:0] rem2;
  logic [12:0] s2;
  logic [12:0] v2;

  logic [12:0] xr_next;
  logic [12:0] xg_next;
  logic [12:0] xb_next;
  logic [12:0] tail;
  logic [12:0] xr3;
  logic [12:0] xg3;
  logic [12:0] xb3;
  logic [12:0] s3;
  logic [12:0] v3;

  assign busy = rst;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LATENCY-2:0], take};
    end
  end

  assign done = valid[LATENCY-1];

  // stage 1: wrap hue, clamp fractions
  always_ff @(posedge clk) begin
    h1 <= (hsv.hue >= HUE_FULL_TURN) ? hsv.hue - HUE_FULL_TURN : hsv.hue;
    s1 <= (hsv.saturation > FRAC_ONE) ? FRAC_ONE : hsv.saturation;
    v1 <= (hsv.brightness > FRAC_ONE) ? FRAC_ONE : hsv.brightness;
  end

  // stage 2: sector and remainder
  always_comb begin
    priority if (h1 < SEC1_BASE) begin
      sec_next  = SEC_0;
      base_next = '0;
    end else if (h1 < SEC2_BASE) begin
      sec_next  = SEC_1;
      base_next = SEC1_BASE;
    end else if (h1 < SEC3_BASE) begin
      sec_next  = SEC_2;
      base_next = SEC2_BASE;
    end else if (h1 < SEC4_BASE) begin
      sec_next  = SEC_3;
      base_next = SEC3_BASE;
    end else if (h1 < SEC5_BASE) begin
      sec_next  = SEC_4;
      base_next = SEC4_BASE;
    end else begin
      sec_next  = SEC_5;
      base_next = SEC5_BASE;
    end
  end

  always_ff @(posedge clk) begin
    sec2 <= sec_next;
    rem2 <= 13'(h1 - base_next);
    s2   <= s1;
    v2   <= v1;
  end

  // stage 3: per-channel weight select (v: 0, p: full, q: rem, t: sector - rem)
  assign tail = HUE_SECTOR - rem2;

  always_comb begin
    unique case (sec2)
      SEC_0: begin
        xr_next = '0;
        xg_next = tail;
        xb_next = HUE_SECTOR;
      end
      SEC_1: begin
        xr_next = rem2;
        xg_next = '0;
        xb_next = HUE_SECTOR;
      end
      SEC_2: begin
        xr_next = HUE_SECTOR;
        xg_next = '0;
        xb_next = tail;
      end
      SEC_3: begin
        xr_next = HUE_SECTOR;
        xg_next = rem2;
        xb_next = '0;
      end
      SEC_4: begin
        xr_next = tail;
        xg_next = HUE_SECTOR;
        xb_next = '0;
      end
      SEC_5: begin
        xr_next = '0;
        xg_next = HUE_SECTOR;
        xb_next = rem2;
      end
      default: begin
        xr_next = '0;
        xg_next = '0;
        xb_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    xr3 <= xr_next;
    xg3 <= xg_next;
    xb3 <= xb_next;
    s3  <= s2;
    v3  <= v2;
  end

  hsv2rgb_chan u_red (
    .clk   (clk),
    .sat   (s3),
    .val   (v3),
    .wsel  (xr3),
    .level (rgb.red_level)
  );

  hsv2rgb_chan u_green (
    .clk   (clk),
    .sat   (s3),
    .val   (v3),
    .wsel  (xg3),
    .level (rgb.green_level)
  );

  hsv2rgb_chan u_blue (
    .clk   (clk),
    .sat   (s3),
    .val   (v3),
    .wsel  (xb3),
    .level (rgb.blue_level)
  );

endmodule

/* sv/hsv2rgb_checker.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks on the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input hsv_t hsv,
  input logic done,
  input rgb_t rgb
);

  // never stalls outside reset
  assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy outside reset");

  // every taken beat comes out as a done beat
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("beat lost");

  // no result without a beat taken
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("unexpected result");

  // zero brightness gives black
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hsv.brightness == '0) |-> ##LATENCY (rgb == '0))
    else $error("black expected");

  // zero saturation gives gray
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hsv.saturation == '0) |-> ##LATENCY
      (rgb.red_level == rgb.green_level && rgb.green_level == rgb.blue_level))
    else $error("gray expected");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .hsv   (hsv),
  .done  (done),
  .rgb   (rgb)
);

/* tb/hsv_to_rgb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches the command and result channels of the HSV to RGB converter. Every
// accepted beat is run through an exact integer model of the conversion, and
// each done beat is compared channel by channel with the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  hsv_t hsv,
  input  logic done,
  input  rgb_t rgb,
  output int   fail_count,
  output int   pending
);

  rgb_t rgb_expected_q[$];

  function automatic logic [7:0] scale_channel(longint unsigned num);
    longint unsigned den;
    den = 64'(FRAC_ONE) * 64'(FRAC_ONE) * 64'(HUE_SECTOR);
    return 8'((num * 64'd255) / den);
  endfunction

  function automatic rgb_t predict_rgb(hsv_t c);
    longint unsigned h, s, v, rem, one, cv, cp, cq, ct, r, g, b;
    sector_t sec;
    rgb_t res;
    h = 64'(c.hue);
    s = 64'(c.saturation);
    v = 64'(c.brightness);
    if (h >= 64'(HUE_FULL_TURN)) h = h - 64'(HUE_FULL_TURN);
    if (s > 64'(FRAC_ONE)) s = 64'(FRAC_ONE);
    if (v > 64'(FRAC_ONE)) v = 64'(FRAC_ONE);
    sec = sector_t'(3'(h / 64'(HUE_SECTOR)));
    rem = h % 64'(HUE_SECTOR);
    one = 64'(FRAC_ONE) * 64'(HUE_SECTOR);
    cv = v * one;
    cp = v * (64'(FRAC_ONE) - s) * 64'(HUE_SECTOR);
    cq = v * (one - s * rem);
    ct = v * (one - s * (64'(HUE_SECTOR) - rem));
    case (sec)
      SEC_0: begin r = cv; g = ct; b = cp; end
      SEC_1: begin r = cq; g = cv; b = cp; end
      SEC_2: begin r = cp; g = cv; b = ct; end
      SEC_3: begin r = cp; g = cq; b = cv; end
      SEC_4: begin r = ct; g = cp; b = cv; end
      default: begin r = cv; g = cp; b = cq; end
    endcase
    res.red_level   = scale_channel(r);
    res.green_level = scale_channel(g);
    res.blue_level  = scale_channel(b);
    return res;
  endfunction

  assign pending = rgb_expected_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    rgb_t want;
    int   errs;
    errs = 0;
    if (!rst) begin
      if (done) begin
        if (rgb_expected_q.size() == 0) begin
          $error("result beat with no command outstanding: %h", rgb);
          errs++;
        end else begin
          want = rgb_expected_q.pop_front();
          if (rgb.red_level !== want.red_level) begin
            $error("red_level: expected %0d, got %0d", want.red_level, rgb.red_level);
            errs++;
          end
          if (rgb.green_level !== want.green_level) begin
            $error("green_level: expected %0d, got %0d", want.green_level,
                   rgb.green_level);
            errs++;
          end
          if (rgb.blue_level !== want.blue_level) begin
            $error("blue_level: expected %0d, got %0d", want.blue_level, rgb.blue_level);
            errs++;
          end
        end
      end
      if (start && !busy) rgb_expected_q.push_back(predict_rgb(hsv));
    end
    if (errs != 0) fail_count <= fail_count + errs;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the HSV to RGB converter. A directed set hits the hue wrap,
// sector boundaries and clamped saturation and value, then random colors
// follow with random idle bursts and one full drain. A separate checker
// predicts and compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_BEATS = 1800;
  localparam int QUIET_TAIL   = 200;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  hsv_t hsv = '0;
  rgb_t rgb;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   beats_sent = 0;
  int   clamped_beats = 0;
  int   sector_hits[6] = '{default: 0};

  always #10 clk = ~clk;

  hsv_to_rgb_converter_top dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .hsv  (hsv),
    .done (done),
    .rgb  (rgb)
  );

  hsv_to_rgb_checker chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .hsv       (hsv),
    .done      (done),
    .rgb       (rgb),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // one command beat, held until taken
  task automatic send_color(hsv_t c);
    int h;
    @(negedge clk);
    start <= 1'b1;
    hsv   <= c;
    while (busy) @(negedge clk);
    @(posedge clk);
    beats_sent++;
    h = c.hue;
    if (h >= HUE_FULL_TURN) h = h - HUE_FULL_TURN;
    sector_hits[h / HUE_SECTOR]++;
    if (c.hue >= HUE_FULL_TURN || c.saturation > FRAC_ONE || c.brightness > FRAC_ONE)
      clamped_beats++;
  endtask

  task automatic idle_burst(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      hsv   <= hsv_t'(42'({$urandom, $urandom}));
    end
  endtask

  function automatic logic [12:0] edge_frac();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'd1;
      2: return FRAC_ONE - 13'd1;
      3: return FRAC_ONE;
      4: return FRAC_ONE + 13'd1;
      default: return 13'h1fff;
    endcase
  endfunction

  function automatic hsv_t random_color();
    hsv_t c;
    int   k;
    case ($urandom_range(0, 9))
      0: c = hsv_t'(42'({$urandom, $urandom}));
      1: begin
        k = $urandom_range(0, 7);
        c.hue        = 16'(k * HUE_SECTOR) + 16'($urandom_range(0, 2)) - 16'd1;
        c.saturation = edge_frac();
        c.brightness = edge_frac();
      end
      default: begin
        c.hue        = 16'($urandom_range(0, HUE_FULL_TURN));
        c.saturation = 13'($urandom_range(0, FRAC_ONE));
        c.brightness = 13'($urandom_range(0, FRAC_ONE));
      end
    endcase
    return c;
  endfunction

  initial begin
    hsv_t directed[$];
    int   wait_cycles;

    directed = '{
      '{16'd0,     FRAC_ONE, FRAC_ONE},
      '{HUE_FULL_TURN, FRAC_ONE, FRAC_ONE},
      '{16'd46081, FRAC_ONE, FRAC_ONE},
      '{16'hffff,  13'h1fff, 13'h1fff},
      '{16'd7679,  FRAC_ONE, FRAC_ONE},
      '{SEC1_BASE, FRAC_ONE, FRAC_ONE},
      '{SEC2_BASE, FRAC_ONE, 13'd2048},
      '{SEC3_BASE, 13'd2048, FRAC_ONE},
      '{SEC4_BASE, FRAC_ONE, FRAC_ONE},
      '{SEC5_BASE, FRAC_ONE, FRAC_ONE},
      '{16'd46079, FRAC_ONE, FRAC_ONE},
      '{16'd3840,  13'd0,    FRAC_ONE},
      '{16'd11520, FRAC_ONE, 13'd0},
      '{16'd19200, 13'd4097, FRAC_ONE},
      '{16'd26880, FRAC_ONE, 13'd4097},
      '{16'd34560, 13'h1fff, 13'd1},
      '{16'd42240, 13'd1,    13'h1fff},
      '{16'd1,     13'd1,    13'd1},
      '{16'd12345, 13'd3000, 13'd1500},
      '{16'd40000, 13'd4095, 13'd4095}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_color(directed[i]);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 2) begin
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (i < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 4) == 0)
        idle_burst($urandom_range(1, 14));
      send_color(random_color());
    end

    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 4 * LATENCY + 20) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk);

    $display("sent %0d color beats, %0d with wrapped hue or clamped fractions",
             beats_sent, clamped_beats);
    $display("beats per hue sector: %0d %0d %0d %0d %0d %0d", sector_hits[0],
             sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4],
             sector_hits[5]);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) $error("%0d results never arrived", pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* hsv_to_rgb_converter_top.f */
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_chan.sv
sv/hsv_to_rgb_converter_top.sv
sv/hsv2rgb_checker.sv
tb/hsv_to_rgb_checker.sv
tb/tb.sv
